### design/moving_average_moisture_percent_unit_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef MOVING_AVERAGE_MOISTURE_PERCENT_UNIT_MACROS_SVH
`define MOVING_AVERAGE_MOISTURE_PERCENT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define MAMP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define MAMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mamp_pkg.sv
package mamp_pkg;

    localparam int WINDOW_DEF  = 10;
    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 16;
    localparam int LEVEL_W     = 12;
    localparam int PCT_W       = 7;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 12;

    // The quotient unit maps the clamped level to a percentage; its dividend
    // is the offset from dry times one hundred.
    localparam int DIVIDEND_W  = 19;
    localparam int DIVISOR_W   = 12;

    localparam logic [LEVEL_W-1:0] DRY_RESET = 12'd4095;
    localparam logic [LEVEL_W-1:0] WET_RESET = 12'd1030;
    localparam logic [PCT_W-1:0]   PCT_SCALE = 7'd100;

    localparam logic [CFG_ADDR_W-1:0] REG_DRY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WET = 1'b1;

    typedef struct packed {
        logic done;
        logic emit;
    } ring_stat_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

### design/moving_average_moisture_percent_unit.sv
// Channel  | Direction | Handshake                  | Payload
// s_       | in        | s_tvalid / s_tready        | s_tdata[11:0] sample
// m_       | out       | m_tvalid / m_tready        | m_tdata[6:0] percent, [18:7] level
// cfg_     | in        | cfg_we (no back-pressure)  | cfg_addr index, cfg_wdata value
//
// A priming sample closes the input for one cycle. A sample that gives a result goes through
// the ring read and write-back, a reciprocal multiply for the average, the clamp and, when
// wet is below dry, the bit-serial percent divider, and then raises m_tvalid. The input
// reopens as m_tvalid rises, so a new sample is taken only once the last one is through.
// Only a full output register with m_tready low stalls the block.
// Reset is synchronous and active low and needs no clearing pass.
module moving_average_moisture_percent_unit
    import mamp_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] sample, rest zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [6:0] moisture_percent, [18:7] smoothed_level
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RING = 3'd1;
    localparam logic [2:0] S_AVG  = 3'd2;
    localparam logic [2:0] S_MAP  = 3'd3;
    localparam logic [2:0] S_PCT  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam int PAD_W = M_TDATA_W - LEVEL_W - PCT_W;

    // The sum divided by WINDOW is exact as a multiply by the rounded-up
    // reciprocal and a right shift, for every sum that fits in SUM_W bits.
    localparam int AVG_SHIFT     = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W       = SUM_W + 1;
    localparam int PROD_W        = SUM_W + RECIP_W;
    localparam int AVG_RECIP_INT = ((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_INT);

    logic [2:0]           state_reg, state_next;
    logic [LEVEL_W-1:0]   dry_reg;
    logic [LEVEL_W-1:0]   wet_reg;
    logic [SUM_W-1:0]     avg_reg, avg_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    ring_stat_t           ring_stat;
    logic [SUM_W-1:0]     ring_sum;
    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic                 in_xfer;
    logic [LEVEL_W-1:0]   offset;
    logic [PROD_W-1:0]    avg_prod;
    logic [SUM_W-1:0]     avg_quot;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign offset   = dry_reg - level_reg;
    assign avg_prod = PROD_W'(ring_sum) * PROD_W'(AVG_RECIP);
    assign avg_quot = SUM_W'(avg_prod >> AVG_SHIFT);

    mamp_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_xfer),
        .in_sample (s_tdata[SAMPLE_W-1:0]),
        .stat      (ring_stat),
        .sum       (ring_sum)
    );

    mamp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next       = state_reg;
        avg_next         = avg_reg;
        level_next       = level_reg;
        pct_next         = pct_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_RING;
                end
            end
            S_RING: begin
                if (ring_stat.done) begin
                    if (ring_stat.emit) begin
                        avg_next   = avg_quot;
                        state_next = S_AVG;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_AVG: begin
                // An average above dry wins over one below wet.
                if (avg_reg > SUM_W'(dry_reg)) begin
                    level_next = dry_reg;
                end else if (avg_reg < SUM_W'(wet_reg)) begin
                    level_next = wet_reg;
                end else begin
                    level_next = avg_reg[LEVEL_W-1:0];
                end
                state_next = S_MAP;
            end
            S_MAP: begin
                if (wet_reg < dry_reg) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIVIDEND_W'(offset) * DIVIDEND_W'(PCT_SCALE);
                    div_req.divisor  = dry_reg - wet_reg;
                    state_next       = S_PCT;
                end else begin
                    pct_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_PCT: begin
                if (div_rsp.done) begin
                    pct_next   = div_rsp.quotient[PCT_W-1:0];
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, level_reg, pct_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        avg_reg     <= avg_next;
        level_reg   <= level_next;
        pct_reg     <= pct_next;
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            dry_reg      <= DRY_RESET;
            wet_reg      <= WET_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_DRY: dry_reg <= cfg_wdata;
                    REG_WET: wet_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### design/mamp_ring.sv
module mamp_ring
    import mamp_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [SAMPLE_W-1:0] in_sample,
    output ring_stat_t          stat,
    output logic [SUM_W-1:0]    sum
);

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];

    logic [CW-1:0]       prime_cnt_reg, prime_cnt_next;
    logic [PW-1:0]       slot_reg, slot_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                pend_reg, pend_next;
    logic                done_reg, done_next;
    logic                emit_reg, emit_next;
    logic [SAMPLE_W-1:0] samp_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic                priming;
    logic                mem_we;
    logic                mem_re;
    logic [PW-1:0]       mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;

    assign priming   = prime_cnt_reg < CW'(WINDOW);
    assign mem_we    = (in_valid && priming) || pend_reg;
    assign mem_re    = in_valid && !priming;
    assign mem_waddr = pend_reg ? slot_reg : prime_cnt_reg[PW-1:0];
    assign mem_wdata = pend_reg ? samp_reg : in_sample;

    // The oldest entry is read in the cycle before it is overwritten; items are
    // taken one at a time, so the read and the write of a slot never overlap.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= ring_mem[slot_reg];
        end
        if (in_valid) begin
            samp_reg <= in_sample;
        end
    end

    always_comb begin
        prime_cnt_next = prime_cnt_reg;
        slot_next      = slot_reg;
        sum_next       = sum_reg;
        pend_next      = 1'b0;
        done_next      = 1'b0;
        emit_next      = 1'b0;
        if (pend_reg) begin
            sum_next  = sum_reg - SUM_W'(rd_data_reg) + SUM_W'(samp_reg);
            slot_next = (slot_reg == PW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            done_next = 1'b1;
            emit_next = 1'b1;
        end else if (in_valid) begin
            if (priming) begin
                sum_next       = sum_reg + SUM_W'(in_sample);
                prime_cnt_next = prime_cnt_reg + 1'b1;
                slot_next      = '0;
                done_next      = 1'b1;
            end else begin
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_cnt_reg <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            emit_reg      <= 1'b0;
        end else begin
            prime_cnt_reg <= prime_cnt_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
            emit_reg      <= emit_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.emit = emit_reg;
    assign sum       = sum_reg;

endmodule

### design/mamp_div.sv
module mamp_div
    import mamp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  fits;

    // Restoring division, one quotient bit per cycle from the top down.
    assign rem_sh  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### design/mamp_checker.sv
`include "moving_average_moisture_percent_unit_macros.svh"

module mamp_checker
    import mamp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A percentage never exceeds one hundred.
    `MAMP_ASSERT_NOW(a_pct_range, m_tvalid, m_tdata[PCT_W-1:0] <= PCT_SCALE, "percent above 100")

    // One sample at a time: the input closes right after a transfer.
    `MAMP_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input open after transfer")

    // A new result appears only as the block finishes work on a sample.
    `MAMP_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result while idle")

    // A stalled result holds.
    `MAMP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed")

endmodule

bind moving_average_moisture_percent_unit mamp_checker u_mamp_checker (.*);

### tb/moving_average_moisture_percent_unit_test.sv
module moving_average_moisture_percent_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mamp_pkg::*;

    localparam int SETTLE_CYCLES  = 64;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [PCT_W-1:0]   percent;
        logic [LEVEL_W-1:0] level;
    } moisture_reading_t;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKED} rx_pattern_t;

    // Tracks the averaging window and the calibration, and holds the readings
    // that the block still owes.
    class moisture_predictor;
        bit [SAMPLE_W-1:0] ring [WINDOW_DEF];
        int unsigned slot;
        int unsigned primed;
        int unsigned window_sum;
        int unsigned dry_level;
        int unsigned wet_level;
        moisture_reading_t expected_readings [$];
        int errors;

        function new();
            dry_level  = DRY_RESET;
            wet_level  = WET_RESET;
            slot       = 0;
            primed     = 0;
            window_sum = 0;
            errors     = 0;
        endfunction

        function void set_levels(int unsigned dry, int unsigned wet);
            dry_level = dry;
            wet_level = wet;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void take_sample(bit [SAMPLE_W-1:0] value);
            int unsigned avg;
            int unsigned span;
            moisture_reading_t reading;
            // The first window of samples after reset only fills the ring.
            if (primed < WINDOW_DEF) begin
                ring[primed] = value;
                window_sum += value;
                primed++;
                slot = 0;
                return;
            end
            window_sum = window_sum - ring[slot] + value;
            ring[slot] = value;
            slot = (slot + 1) % WINDOW_DEF;
            avg = window_sum / WINDOW_DEF;
            if (avg > dry_level) begin
                avg = dry_level;
            end else if (avg < wet_level) begin
                avg = wet_level;
            end
            reading.level   = avg[LEVEL_W-1:0];
            reading.percent = '0;
            if (wet_level < dry_level) begin
                span = dry_level - wet_level;
                reading.percent = PCT_W'((dry_level - avg) * PCT_SCALE / span);
            end
            expected_readings.push_back(reading);
        endfunction

        function void compare_reading(logic [PCT_W-1:0] percent, logic [LEVEL_W-1:0] level);
            moisture_reading_t want;
            if (expected_readings.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("unexpected reading: percent %0d level %0d", percent, level);
                end
                return;
            end
            want = expected_readings.pop_front();
            if (percent !== want.percent || level !== want.level) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("reading mismatch: expected percent %0d level %0d, got percent %0d level %0d",
                             want.percent, want.level, percent, level);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [11:0] sample
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [6:0] moisture_percent, [18:7] smoothed_level
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    moisture_predictor predictor;
    int burst_left;
    int hold_requests;
    int hold_served;

    logic [SAMPLE_W-1:0] directed_samples [25] = '{
        12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd4095, 12'd0, 12'd1, 12'd4094,
        12'd2048, 12'd2047,
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
        12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0
    };

    moving_average_moisture_percent_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            predictor.compare_reading(m_tdata[PCT_W-1:0], m_tdata[PCT_W +: LEVEL_W]);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // The receiver changes its stall pattern every segment and serves
    // long hold-off requests from the stimulus process.
    initial begin : receiver
        int k;
        int seg_len;
        int period;
        rx_pattern_t pattern;
        m_tready = 1'b0;
        forever begin
            pattern = rx_pattern_t'($urandom_range(0, 3));
            seg_len = (pattern == RX_BLOCKED) ? $urandom_range(5, 80) : $urandom_range(20, 200);
            period  = $urandom_range(2, 5);
            for (k = 0; k < seg_len; k++) begin
                @(negedge aclk);
                if (hold_requests > hold_served) begin
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge aclk);
                    hold_served++;
                end else begin
                    case (pattern)
                        RX_OPEN:     m_tready <= 1'b1;
                        RX_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
                        RX_PERIODIC: m_tready <= ((k % period) == 0);
                        default:     m_tready <= 1'b0;
                    endcase
                end
            end
        end
    end

    task automatic pause_sender(input int cycles);
        @(negedge aclk) s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic offer(input logic [SAMPLE_W-1:0] value, input bit gapless);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(value);
        do @(posedge aclk); while (!s_tready);
        predictor.take_sample(value);
        if (!gapless) begin
            burst_left--;
            if (burst_left <= 0) begin
                pause_sender($urandom_range(1, 90));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 8);
            end
        end
    endtask

    // Waits for every owed reading, then long enough for a priming sample
    // still in work to finish.
    task automatic settle();
        while (predictor.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_levels(input int unsigned dry, input int unsigned wet);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_DRY;
        cfg_wdata <= CFG_DATA_W'(dry);
        @(negedge aclk);
        cfg_addr  <= REG_WET;
        cfg_wdata <= CFG_DATA_W'(wet);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        predictor.set_levels(dry, wet);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int center, input int spread);
        int v;
        if ($urandom_range(0, 3) == 0) begin
            return SAMPLE_W'($urandom_range(0, 4095));
        end
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic run_phase(input int unsigned dry, input int unsigned wet, input int count,
                             input int center, input int spread,
                             input bit gapless, input bit hold_receiver);
        int n;
        settle();
        write_levels(dry, wet);
        if (hold_receiver) begin
            hold_requests++;
        end
        for (n = 0; n < count; n++) begin
            offer(pick_sample(center, spread), gapless);
        end
        pause_sender(1);
    endtask

    initial begin : stimulus
        int i;
        int unsigned dry;
        int unsigned wet;
        int center;
        predictor     = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_DRY;
        cfg_wdata     = '0;
        burst_left    = 4;
        hold_requests = 0;
        hold_served   = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Priming with extreme and alternating bit patterns, then full-scale
        // runs that drive the average toward both ends of the reset calibration.
        for (i = 0; i < 25; i++) begin
            offer(directed_samples[i], 1'b0);
        end
        pause_sender(1);

        run_phase(4095, 0,    60, 2048, 2048, 1'b0, 1'b0);
        // Averages mostly above a tiny dry level.
        run_phase(1,    0,    40, 60,   60,   1'b0, 1'b0);
        run_phase(4095, 4094, 40, 4090, 10,   1'b0, 1'b0);
        // Wet equal to dry and wet above dry leave the percentage at zero.
        run_phase(2000, 2000, 40, 2000, 400,  1'b0, 1'b0);
        run_phase(100,  3000, 40, 1500, 1500, 1'b0, 1'b0);
        // The receiver holds off while the sender keeps offering.
        run_phase(3500, 1200, 60, 2300, 1500, 1'b1, 1'b1);

        for (i = 0; i < 6; i++) begin
            dry = $urandom_range(1, 4095);
            wet = $urandom_range(0, 4094);
            case ($urandom_range(0, 2))
                0:       center = dry;
                1:       center = wet;
                default: center = $urandom_range(0, 4095);
            endcase
            run_phase(dry, wet, 40, center, $urandom_range(0, 600), 1'b0, 1'b0);
        end

        settle();
        if (predictor.errors == 0 && predictor.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
